>>> hw/rtl/bskd_pkg.sv
// Shared types and codes for the bucketed sorted key dictionary.
package bskd_pkg;

  localparam int unsigned KeyW = 160;
  localparam int unsigned ValW = 32;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_HIT      = 3'd1,
    ST_MISS     = 3'd2,
    ST_DUP      = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CNT,
    S_SRCH,
    S_CMP,
    S_SHRD,
    S_SHWR,
    S_DONE,
    S_CLR
  } state_e;

  typedef struct packed {
    logic        cmd;
    logic [63:0] key_high;
    logic [63:0] key_mid;
    logic [31:0] key_low;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_value;
  } rsp_t;

endpackage

>>> hw/rtl/bucketed_sorted_key_dictionary.sv
// Top level of the bucketed sorted key dictionary.
// One command at a time: busy is high from the accepting edge through the
// result cycle. After reset busy stays high while the per-bucket counts are
// cleared one per cycle; the entry store needs no clearing. Per command: the
// bucket count is read as the command is taken, then each binary-search
// probe is one read of the single-port entry store and one 160-bit compare,
// up to ceil(log2(BUCKET_DEPTH+1)) probes; a search that ends without a match
// is closed in the search state, then on insert each entry moved up is read
// and written back one slot higher, then the new pair is written, then the
// result cycle follows. The result shows on result_o for one cycle with
// done_o high and cannot be held off.
module bucketed_sorted_key_dictionary import bskd_pkg::*; #(
  parameter int unsigned BUCKET_BITS  = 8,
  parameter int unsigned BUCKET_DEPTH = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t result_o
);

  localparam int unsigned NB = 2**BUCKET_BITS;
  localparam int unsigned SW = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned AW = $clog2(NB * BUCKET_DEPTH) < 1 ? 1
                               : $clog2(NB * BUCKET_DEPTH);

  state_e state_q, state_d;
  req_t   req_q, req_d;
  logic [SW-1:0] lo_q, lo_d, hi_q, hi_d, len_q, len_d, idx_q, idx_d, mid;
  logic [3:0]    cnt_q [NB];
  logic [3:0]    cnt_rd_q;
  logic          hit_q, hit_d;
  rsp_t          rsp_q, rsp_d;
  logic [BUCKET_BITS-1:0] bkt;
  logic [BUCKET_BITS-1:0] clr_q, clr_d;

  logic                 we;
  logic [AW-1:0]        addr;
  logic [KeyW+ValW-1:0] wdata, rdata;
  logic [KeyW-1:0]      skey, pkey;
  logic                 cnt_we;
  logic [BUCKET_BITS-1:0] cnt_wa, cnt_ra;
  logic [3:0]           cnt_wd;

  assign bkt    = req_q.key_high[63 -: BUCKET_BITS];
  assign cnt_ra = req_d.key_high[63 -: BUCKET_BITS];
  assign mid    = SW'((({1'b0, lo_q} + {1'b0, hi_q}) >> 1));
  assign skey   = rdata[KeyW+ValW-1:ValW];
  assign pkey   = {req_q.key_high, req_q.key_mid, req_q.key_low};

  bskd_store #(.AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  function automatic logic [AW-1:0] slot(logic [BUCKET_BITS-1:0] b, logic [SW-1:0] i);
    return AW'(b * BUCKET_DEPTH + i);
  endfunction

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    len_d   = len_q;
    idx_d   = idx_q;
    hit_d   = hit_q;
    rsp_d   = rsp_q;
    clr_d   = clr_q;
    we      = 1'b0;
    cnt_we  = 1'b0;
    cnt_wa  = bkt;
    cnt_wd  = 4'(len_q + SW'(1));
    addr    = slot(bkt, mid);
    wdata   = rdata;
    case (state_q)
      S_CLR: begin
        // clear one bucket count per cycle after reset
        cnt_we = 1'b1;
        cnt_wa = clr_q;
        cnt_wd = '0;
        clr_d  = clr_q + BUCKET_BITS'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = S_CNT;
        end
      end
      S_CNT: begin
        len_d   = (cnt_rd_q > 4'(BUCKET_DEPTH)) ? SW'(BUCKET_DEPTH) : SW'(cnt_rd_q);
        lo_d    = '0;
        hi_d    = (cnt_rd_q > 4'(BUCKET_DEPTH)) ? SW'(BUCKET_DEPTH) : SW'(cnt_rd_q);
        hit_d   = 1'b0;
        state_d = S_SRCH;
      end
      S_SRCH: begin
        // issue read of the middle entry, or finish the search
        if (lo_q < hi_q) begin
          state_d = S_CMP;
        end else begin
          rsp_d.found_value = '0;
          if (req_q.cmd == CMD_LOOKUP) begin
            rsp_d.status = ST_MISS;
            state_d      = S_DONE;
          end else if (len_q >= SW'(BUCKET_DEPTH)) begin
            rsp_d.status = ST_FULL;
            state_d      = S_DONE;
          end else begin
            rsp_d.status = ST_INSERTED;
            idx_d        = len_q;
            state_d      = S_SHRD;
          end
        end
      end
      S_CMP: begin
        if (skey == pkey) begin
          hit_d   = 1'b1;
          state_d = S_DONE;
          if (req_q.cmd == CMD_LOOKUP) begin
            rsp_d.status      = ST_HIT;
            rsp_d.found_value = rdata[ValW-1:0];
          end else begin
            rsp_d.status      = ST_DUP;
            rsp_d.found_value = '0;
          end
        end else begin
          if (skey < pkey) lo_d = mid + SW'(1);
          else             hi_d = mid;
          state_d = S_SRCH;
        end
      end
      S_SHRD: begin
        // read the word below idx, or write the new pair at the insert point
        if (idx_q > lo_q) begin
          addr    = slot(bkt, idx_q - SW'(1));
          state_d = S_SHWR;
        end else begin
          addr    = slot(bkt, lo_q);
          wdata   = {pkey, req_q.value};
          we      = 1'b1;
          cnt_we  = 1'b1;
          state_d = S_DONE;
        end
      end
      S_SHWR: begin
        addr    = slot(bkt, idx_q);
        we      = 1'b1;
        idx_d   = idx_q - SW'(1);
        state_d = S_SHRD;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    len_q    <= len_d;
    idx_q    <= idx_d;
    hit_q    <= hit_d;
    rsp_q    <= rsp_d;
    if (cnt_we) cnt_q[cnt_wa] <= cnt_wd;
    cnt_rd_q <= cnt_q[cnt_ra];
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = (state_q == S_DONE);
  assign result_o = rsp_q;

  a_hit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit_q |-> (result_o.status == ST_HIT || result_o.status == ST_DUP))
    else $error("hit without hit/dup status");
  a_write_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> req_q.cmd == CMD_INSERT)
    else $error("store written on lookup");
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SRCH |-> (lo_q <= hi_q && hi_q <= len_q))
    else $error("search bounds out of order");

endmodule

>>> hw/rtl/bskd_store.sv
// Entry store: one memory of key/value words, one port, registered read.
module bskd_store import bskd_pkg::*; #(
  parameter int unsigned AW = 11
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        addr_i,
  input  logic [KeyW+ValW-1:0] wdata_i,
  output logic [KeyW+ValW-1:0] rdata_o
);

  logic [KeyW+ValW-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> sim/bucketed_sorted_key_dictionary_tb.sv
// Testbench for the bucketed sorted key dictionary: directed and random commands against a predictor.
module bucketed_sorted_key_dictionary_tb import bskd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BucketBits  = 8;
  localparam int unsigned BucketDepth = 8;
  localparam int unsigned NumBuckets  = 1 << BucketBits;
  localparam longint unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [63:0] kh;
    logic [63:0] km;
    logic [31:0] kl;
  } key_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  rsp_t result_o;

  // predictor state: each bucket as a sorted list
  key_t        dict_key[NumBuckets][$];
  logic [31:0] dict_val[NumBuckets][$];
  rsp_t        expected_rsp[$];
  key_t        used_keys[$];
  int          errors = 0;
  longint unsigned cycles = 0;

  bucketed_sorted_key_dictionary #(
    .BUCKET_BITS (BucketBits),
    .BUCKET_DEPTH(BucketDepth)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic rsp_t predict_dictionary(req_t r);
    key_t k;
    int unsigned b;
    int unsigned pos;
    rsp_t o;
    k = '{r.key_high, r.key_mid, r.key_low};
    b = 32'(r.key_high[63 -: BucketBits]);
    o = '0;
    pos = 0;
    while (pos < dict_key[b].size() && dict_key[b][pos] < k) pos++;
    if (r.cmd == CMD_LOOKUP) begin
      if (pos < dict_key[b].size() && dict_key[b][pos] == k) begin
        o.status = ST_HIT;
        o.found_value = dict_val[b][pos];
      end else begin
        o.status = ST_MISS;
      end
    end else if (pos < dict_key[b].size() && dict_key[b][pos] == k) begin
      o.status = ST_DUP;
    end else if (dict_key[b].size() >= BucketDepth) begin
      o.status = ST_FULL;
    end else begin
      dict_key[b].insert(pos, k);
      dict_val[b].insert(pos, r.value);
      o.status = ST_INSERTED;
    end
    return o;
  endfunction

  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected word, actual status %0d value %h",
                 $realtime, result_o.status, result_o.found_value);
        errors++;
      end else begin
        exp_rsp = expected_rsp.pop_front();
        if (result_o.status !== exp_rsp.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $realtime, exp_rsp.status, result_o.status);
          errors++;
        end
        if (result_o.found_value !== exp_rsp.found_value) begin
          $display("%0t: found_value mismatch, expected %h actual %h",
                   $realtime, exp_rsp.found_value, result_o.found_value);
          errors++;
        end
      end
    end
  end

  task automatic send_word(cmd_e cmd, key_t k, logic [31:0] val);
    int gap;
    req_t r;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(posedge clk_i);
    r = '{cmd, k.kh, k.km, k.kl, val};
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_rsp.push_back(predict_dictionary(r));
    used_keys.push_back(k);
    start <= 1'b0;
    req_i <= '{cmd: 1'($urandom()), key_high: {$urandom(), $urandom()},
               key_mid: {$urandom(), $urandom()}, key_low: $urandom(), value: $urandom()};
    @(posedge clk_i);
  endtask

  function automatic key_t random_key(int unsigned b);
    key_t k;
    k.kh = {$urandom(), $urandom()};
    k.km = {$urandom(), $urandom()};
    k.kl = $urandom();
    k.kh[63 -: BucketBits] = BucketBits'(b);
    return k;
  endfunction

  // extremes of key fields, equal high parts differing only in low bits
  task automatic test_extremes();
    key_t k;
    k = '{64'h0, 64'h0, 32'h0};
    send_word(CMD_LOOKUP, k, 32'hFFFF_FFFF);
    send_word(CMD_INSERT, k, 32'h0);
    send_word(CMD_LOOKUP, k, 32'h0);
    k = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF};
    send_word(CMD_INSERT, k, 32'hFFFF_FFFF);
    send_word(CMD_INSERT, k, 32'h1234_5678);
    send_word(CMD_LOOKUP, k, 32'h0);
    k.kl = 32'hFFFF_FFFE;
    send_word(CMD_LOOKUP, k, 32'h0);
    send_word(CMD_INSERT, k, 32'hA5A5_A5A5);
    k.km = 64'h0;
    send_word(CMD_INSERT, k, 32'h5A5A_5A5A);
    send_word(CMD_LOOKUP, k, 32'h0);
  endtask

  // fill one bucket past depth in descending order, then duplicate in full bucket
  task automatic test_full_bucket();
    key_t k;
    for (int i = 0; i < BucketDepth + 2; i++) begin
      k = '{{8'h42, 56'h0}, 64'h0, 32'(100 - i)};
      send_word(CMD_INSERT, k, 32'(i));
    end
    send_word(CMD_INSERT, '{{8'h42, 56'h0}, 64'h0, 32'd100}, 32'd9);
    for (int i = 0; i < BucketDepth; i++)
      send_word(CMD_LOOKUP, '{{8'h42, 56'h0}, 64'h0, 32'(93 + i)}, 32'd0);
  endtask

  // few buckets so they fill up; lookups and duplicates of earlier keys
  task automatic test_random(int n);
    key_t k;
    int unsigned b;
    for (int i = 0; i < n; i++) begin
      b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NumBuckets - 1)
                                      : $urandom_range(0, 15) * 16;
      k = random_key(b);
      if (used_keys.size() > 0 && $urandom_range(0, 1))
        k = used_keys[$urandom_range(0, used_keys.size() - 1)];
      send_word(cmd_e'($urandom_range(0, 1)), k, $urandom());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_full_bucket();
    test_random(900);
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
